// ===== rtl/ckc_pkg.sv =====
// ============================================================================
// ckc_pkg: shared types and constants of the c keyword counter
// Character codes, the sorted keyword rom, the scanner and back-end state
// types and the command that travels from the scanner to the counter.
// ============================================================================
`default_nettype none

package ckc_pkg;

    // keyword rom geometry
    localparam int ROM_KEYS    = 11;
    localparam int IDX_W       = 4;
    localparam int KEY_BYTES   = 8;
    localparam int WORD_W      = 8 * KEY_BYTES;
    localparam int COUNT_OUT_W = 16;

    // defaults for the top-level parameters
    localparam int DEF_NUM_KEYS    = 11;
    localparam int DEF_MAX_WORD    = 100;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    // character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_STAR       = 8'h2a;
    localparam logic [7:0] CH_SLASH      = 8'h2f;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7a;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_WORD,
        MODE_STRING,
        MODE_LINE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STAR
    } scan_mode_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_REPORT
    } back_state_t;

    // word bytes are kept with the first character in the top byte, so
    // that a plain unsigned compare gives dictionary order
    typedef struct packed {
        logic              is_end;
        logic              has_word;
        logic [WORD_W-1:0] chars;
    } ckc_cmd_t;

    function automatic logic [WORD_W-1:0] key_rom(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] row;
        unique case (idx)
            4'd0:    row = 64'h6175746f00000000;  // auto
            4'd1:    row = 64'h627265616b000000;  // break
            4'd2:    row = 64'h6361736500000000;  // case
            4'd3:    row = 64'h6368617200000000;  // char
            4'd4:    row = 64'h636f6e7374000000;  // const
            4'd5:    row = 64'h636f6e74696e7565;  // continue
            4'd6:    row = 64'h64656661756c7400;  // default
            4'd7:    row = 64'h756e7369676e6564;  // unsigned
            4'd8:    row = 64'h766f696400000000;  // void
            4'd9:    row = 64'h766f6c6174696c65;  // volatile
            4'd10:   row = 64'h7768696c65000000;  // while
            default: row = '0;
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ckc_scan.sv =====
// ============================================================================
// ckc_scan: text scanner of the c keyword counter
// Tracks strings, line directives and comments, collects words and issues a
// lookup command for each qualifying word and an end command for end of text.
// ============================================================================
`default_nettype none

module ckc_scan #(
    parameter int MAX_WORD = ckc_pkg::DEF_MAX_WORD
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       char_code,
    input  wire logic             end_of_text,
    output logic                  push,
    output ckc_pkg::ckc_cmd_t     cmd
);
    import ckc_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD);
    localparam logic LONG_AT_START = (MAX_WORD <= 2);

    scan_mode_t        mode_reg, mode_next, start_mode;
    logic [WORD_W-1:0] chars_reg, chars_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W:0]    len_inc;
    logic              too_long_reg, too_long_next;
    logic              letter_reg, letter_next;

    logic is_letter, is_digit, is_space, word_cont, word_end, qualify;
    logic ts_apply, start_word, append;

    always_comb
    begin
        is_letter = ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z)) ||
                    ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z));
        is_digit  = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
        is_space  = (char_code == CH_SPACE) ||
                    ((char_code >= CH_TAB) && (char_code <= CH_CR));
        priority if (is_space)
            start_mode = MODE_NORMAL;
        else if (char_code == CH_QUOTE)
            start_mode = MODE_STRING;
        else if (char_code == CH_HASH)
            start_mode = MODE_LINE;
        else if (char_code == CH_SLASH)
            start_mode = MODE_SLASH;
        else if (is_letter || (char_code == CH_UNDERSCORE))
            start_mode = MODE_WORD;
        else
            start_mode = MODE_NORMAL;
    end

    assign word_cont = (is_letter || is_digit) && !too_long_reg;
    assign word_end  = accept && (mode_reg == MODE_WORD) && (end_of_text || !word_cont);
    assign qualify   = letter_reg && (32'(len_reg) <= 32'(KEY_BYTES));
    assign len_inc   = {1'b0, len_reg} + {{LEN_W{1'b0}}, 1'b1};

    // next scanner mode
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                mode_next = MODE_NORMAL;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_NORMAL:  mode_next = start_mode;
                    MODE_WORD:    mode_next = word_cont ? MODE_WORD : start_mode;
                    MODE_STRING:  mode_next = (char_code == CH_QUOTE) ? MODE_NORMAL
                                                                      : MODE_STRING;
                    MODE_LINE:    mode_next = (char_code == CH_NEWLINE) ? MODE_NORMAL
                                                                        : MODE_LINE;
                    MODE_SLASH:   mode_next = (char_code == CH_STAR) ? MODE_COMMENT
                                                                     : start_mode;
                    MODE_COMMENT: mode_next = (char_code == CH_STAR) ? MODE_STAR
                                                                     : MODE_COMMENT;
                    MODE_STAR:
                    begin
                        priority if (char_code == CH_SLASH)
                            mode_next = MODE_NORMAL;
                        else if (char_code == CH_STAR)
                            mode_next = MODE_STAR;
                        else
                            mode_next = MODE_COMMENT;
                    end
                    default:      mode_next = MODE_NORMAL;
                endcase
            end
        end
    end

    // word buffer and command output
    always_comb
    begin
        ts_apply   = (mode_reg == MODE_NORMAL) ||
                     ((mode_reg == MODE_SLASH) && (char_code != CH_STAR)) || word_end;
        start_word = accept && !end_of_text && ts_apply && (start_mode == MODE_WORD);
        append     = accept && !end_of_text && (mode_reg == MODE_WORD) && word_cont;

        chars_next    = chars_reg;
        len_next      = len_reg;
        too_long_next = too_long_reg;
        letter_next   = letter_reg;

        if (start_word)
        begin
            chars_next    = {char_code, {(WORD_W-8){1'b0}}};
            len_next      = LEN_W'(1);
            too_long_next = LONG_AT_START;
            letter_next   = is_letter;
        end
        else if (append)
        begin
            for (int i = 0; i < KEY_BYTES; i++)
            begin
                if (32'(len_reg) == i)
                    chars_next[WORD_W-1-8*i -: 8] = char_code;
            end
            len_next      = len_inc[LEN_W-1:0];
            too_long_next = (len_inc >= (LEN_W+1)'(MAX_WORD-1));
        end
        else if (word_end || (accept && end_of_text))
        begin
            chars_next    = '0;
            len_next      = '0;
            too_long_next = 1'b0;
            letter_next   = 1'b0;
        end

        push         = accept && (end_of_text || (word_end && qualify));
        cmd.is_end   = end_of_text;
        cmd.has_word = word_end && qualify;
        cmd.chars    = chars_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NORMAL;
            chars_reg    <= '0;
            len_reg      <= '0;
            too_long_reg <= 1'b0;
            letter_reg   <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            chars_reg    <= chars_next;
            len_reg      <= len_next;
            too_long_reg <= too_long_next;
            letter_reg   <= letter_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ckc_fifo.sv =====
// ============================================================================
// ckc_fifo: command queue of the c keyword counter
// Small first-in first-out queue between the scanner and the counter.
// ============================================================================
`default_nettype none

module ckc_fifo #(
    parameter int DEPTH = ckc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ckc_pkg::ckc_cmd_t push_cmd,
    input  wire logic              pop,
    output logic                   full,
    output logic                   empty,
    output ckc_pkg::ckc_cmd_t      head_cmd
);
    import ckc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ckc_cmd_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ckc_count.sv =====
// ============================================================================
// ckc_count: lookup and report engine of the c keyword counter
// Binary search of the keyword rom, saturating counters and the
// end-of-text report through an output register.
// ============================================================================
`default_nettype none

module ckc_count #(
    parameter int NUM_KEYS   = ckc_pkg::DEF_NUM_KEYS,
    parameter int COUNT_BITS = ckc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire ckc_pkg::ckc_cmd_t             cmd,
    output logic                               pop,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [ckc_pkg::IDX_W-1:0]          out_index,
    output logic [ckc_pkg::COUNT_OUT_W-1:0]    out_count,
    output logic                               out_last
);
    import ckc_pkg::*;

    localparam int ACTIVE_KEYS = (NUM_KEYS < ROM_KEYS) ? NUM_KEYS : ROM_KEYS;
    localparam int CI_W        = (ACTIVE_KEYS > 1) ? $clog2(ACTIVE_KEYS) : 1;

    back_state_t       state_reg, state_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic              end_reg, end_next;
    logic [IDX_W-1:0]  low_reg, low_next;
    logic [IDX_W-1:0]  high_reg, high_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [COUNT_BITS-1:0] counts_reg [ACTIVE_KEYS];
    logic [COUNT_BITS-1:0] counts_next [ACTIVE_KEYS];

    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       out_index_reg, out_index_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic                   out_last_reg, out_last_next;

    logic [IDX_W:0]          mid_sum;
    logic [IDX_W-1:0]        mid, rd_idx;
    logic [WORD_W-1:0]       rom_row;
    logic                    miss, hit, less;
    logic [COUNT_BITS-1:0]   rd_count;
    logic [31:0]             cnt_wide;
    logic [COUNT_OUT_W-1:0]  cnt_sat;
    logic [ACTIVE_KEYS-1:0]  nz_mask, rest;
    logic                    none, here, more, out_free;

    assign mid_sum  = {1'b0, low_reg} + {1'b0, high_reg} - {{IDX_W{1'b0}}, 1'b1};
    assign mid      = mid_sum[IDX_W:1];
    assign rom_row  = key_rom(mid);
    assign miss     = (low_reg >= high_reg);
    assign hit      = !miss && (key_reg == rom_row);
    assign less     = key_reg < rom_row;
    assign rd_idx   = (state_reg == BK_REPORT) ? idx_reg : mid;
    assign rd_count = counts_reg[rd_idx[CI_W-1:0]];
    assign cnt_wide = 32'(rd_count);
    assign cnt_sat  = (cnt_wide > 32'h0000ffff) ? {COUNT_OUT_W{1'b1}}
                                                : cnt_wide[COUNT_OUT_W-1:0];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < ACTIVE_KEYS; i++)
            nz_mask[i] = (counts_reg[i] != '0);
        rest = nz_mask >> idx_reg;
        none = (nz_mask == '0);
        here = rest[0];
        more = |(rest >> 1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    priority if (cmd.has_word)
                        state_next = BK_SEARCH;
                    else if (cmd.is_end)
                        state_next = BK_REPORT;
                    else
                        state_next = BK_IDLE;
                end
            end
            BK_SEARCH:
            begin
                if (miss || hit)
                    state_next = end_reg ? BK_REPORT : BK_IDLE;
            end
            BK_REPORT:
            begin
                if (out_free && (none || (here && !more)))
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        key_next       = key_reg;
        end_next       = end_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        idx_next       = idx_reg;
        counts_next    = counts_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                pop = cmd_valid;
                if (cmd_valid)
                begin
                    key_next  = cmd.chars;
                    end_next  = cmd.is_end;
                    low_next  = '0;
                    high_next = IDX_W'(ACTIVE_KEYS);
                    idx_next  = '0;
                end
            end
            BK_SEARCH:
            begin
                if (hit)
                begin
                    if (rd_count != {COUNT_BITS{1'b1}})
                        counts_next[mid[CI_W-1:0]] = rd_count + 1'b1;
                    low_next = high_reg;
                end
                else if (!miss)
                begin
                    if (less)
                        high_next = mid;
                    else
                        low_next = mid + 1'b1;
                end
            end
            BK_REPORT:
            begin
                if (none)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = '0;
                        out_count_next = '0;
                        out_last_next  = 1'b1;
                        for (int i = 0; i < ACTIVE_KEYS; i++)
                            counts_next[i] = '0;
                    end
                end
                else if (here)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = idx_reg;
                        out_count_next = cnt_sat;
                        out_last_next  = !more;
                        idx_next       = idx_reg + 1'b1;
                        if (!more)
                        begin
                            for (int i = 0; i < ACTIVE_KEYS; i++)
                                counts_next[i] = '0;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        end_reg       <= end_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        idx_reg       <= idx_next;
        out_index_reg <= out_index_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ACTIVE_KEYS; i++)
                counts_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            counts_reg    <= counts_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/c_keyword_counter.sv =====
// ============================================================================
// c_keyword_counter: keyword frequency counter for c source text
// Counts eleven fixed c keywords in a byte stream and reports the counts on
// end of text.
// ============================================================================
// The block takes one text byte per transfer on the slave side; tlast set
// marks end of text (its data byte is ignored), which closes any open word
// and starts the count report. The scanner takes a byte in every cycle as
// long as its four-entry command queue has room. Each finished word that
// starts with a letter and is at most eight characters long becomes a queue
// entry; the counter pops it while idle and binary searches the sorted
// keyword rom with one 64-bit compare per cycle, at most four compares plus
// a last check that sees an empty range on a miss, while plain bytes cost
// nothing in the back end. Sustained text therefore runs at one byte per
// cycle until short words arrive faster than the back end can search them.
// The report sends one transfer per nonzero keyword, in rom order, at most
// one per cycle, and each zero counter skipped takes a step of its own;
// with no keyword seen it sends a single entry of index zero and count zero.
// tlast marks the final entry, after which the counters are zero again.
// Reset clears the counters at once; no clearing pass is needed.
`default_nettype none

module c_keyword_counter #(
    parameter int NUM_KEYS    = ckc_pkg::DEF_NUM_KEYS,
    parameter int MAX_WORD    = ckc_pkg::DEF_MAX_WORD,
    parameter int COUNT_BITS  = ckc_pkg::DEF_COUNT_BITS,
    parameter int QUEUE_DEPTH = ckc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // text input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_text
    // report output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] key_index, [19:4] key_count, rest zero
    output logic             m_tlast    // report_last
);
    import ckc_pkg::*;

    logic                   accept;
    logic                   push, full, empty, pop;
    ckc_cmd_t               push_cmd, head_cmd;
    logic [IDX_W-1:0]       key_index;
    logic [COUNT_OUT_W-1:0] key_count;

    // the scanner only moves when a transfer is taken
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    ckc_scan #(
        .MAX_WORD (MAX_WORD)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .cmd         (push_cmd)
    );

    // commands: finished words and end of text, in text order
    ckc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    ckc_count #(
        .NUM_KEYS   (NUM_KEYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_index (key_index),
        .out_count (key_count),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, key_count, key_index};

endmodule

`default_nettype wire

// ===== rtl/ckc_checker.sv =====
// ============================================================================
// ckc_checker: port checks of the c keyword counter
// Watches the report channel over time.
// ============================================================================
`default_nettype none

module ckc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("report valid right after reset");

    // a held transfer keeps its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled report transfer changed");

    // only the empty report carries a zero count, and it ends the report
    a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[19:4] == 16'd0) |-> m_tlast && (m_tdata[3:0] == 4'd0))
        else $error("zero count outside an empty report");

    // keyword index within the rom and padding clear
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd10) && (m_tdata[23:20] == 4'd0))
        else $error("bad keyword index or padding");

endmodule

bind c_keyword_counter ckc_checker u_checker (.*);

`default_nettype wire
